// ===== src/stream_find_and_replace_assert.svh =====
// Assertion macros shared by the find-and-replace modules.
// Every macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef STREAM_FIND_AND_REPLACE_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sfr_pkg.sv =====
// Shared types and constants of the stream find-and-replace block.
// No dependencies; every file of the block but the assertion header uses it.
package sfr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int BUF_DEPTH   = PATTERN_MAX - 1;
    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 3;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = 1;
    localparam int Q_CW        = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] CFG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

    typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] t_bytes;

    // Configuration as seen by the datapath, lengths already clamped.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern;
        logic [LEN_W-1:0]      plen;
        logic [CFG_DATA_W-1:0] repl;
        logic [LEN_W-1:0]      rlen;
    } t_cfg;

    // One output run: literal bytes, then replacement bytes, or an end marker.
    typedef struct packed {
        t_bytes           lit;
        logic [LEN_W-1:0] lit_cnt;
        logic [CNT_W-1:0] beats_m1;
        logic             marker;
        logic             text_end;
    } t_cmd;

endpackage

// ===== src/sfr_in_if.sv =====
// Input text channel: one text byte and its end flag per beat.
// Depends on sfr_pkg for widths.
interface sfr_in_if;
    logic                       valid;
    logic                       ready;
    logic [sfr_pkg::BYTE_W-1:0] text_byte;
    logic                       text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

// ===== src/sfr_out_if.sv =====
// Output text channel: one emitted byte with its framing flags per beat.
// Depends on sfr_pkg for widths.
interface sfr_out_if;
    logic                       valid;
    logic                       ready;
    logic [sfr_pkg::BYTE_W-1:0] out_byte;
    logic                       byte_valid;
    logic                       run_last;
    logic                       output_end;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output output_end, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input run_last,
                  input output_end, output ready);
endinterface

// ===== src/sfr_front.sv =====
// Front end: accepts text bytes, tracks the pending prefix and issues run commands.
// Depends on sfr_pkg and sfr_in_if.
module sfr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sfr_in_if.sink               i_text,
    input  sfr_pkg::t_cfg        i_cfg,
    input  logic                 i_full,
    output logic                 o_push,
    output sfr_pkg::t_cmd        o_cmd
);

    logic [sfr_pkg::BYTE_W-1:0]  r_buf [sfr_pkg::BUF_DEPTH];
    logic [sfr_pkg::BYTE_W-1:0]  n_buf [sfr_pkg::BUF_DEPTH];
    logic [sfr_pkg::CNT_W-1:0]   r_cnt;
    logic [sfr_pkg::CNT_W-1:0]   n_cnt;

    sfr_pkg::t_bytes             work;
    logic [sfr_pkg::LEN_W-1:0]   n_work;
    logic [sfr_pkg::PATTERN_MAX:0] ok;
    logic [sfr_pkg::LEN_W-1:0]   shift;
    logic [sfr_pkg::LEN_W-1:0]   rel;
    logic [sfr_pkg::LEN_W-1:0]   keep;
    logic [sfr_pkg::LEN_W-1:0]   beats;
    logic                        passthru;
    logic                        match;
    logic                        accept;

    assign i_text.ready = !i_full;
    assign accept       = i_text.valid && i_text.ready;

    // Held bytes followed by the new byte, and the search for the shortest release.
    always_comb begin
        for (int i = 0; i < sfr_pkg::BUF_DEPTH; i++) begin
            work[i] = (sfr_pkg::CNT_W'(i) < r_cnt) ? r_buf[i] : i_text.text_byte;
        end
        work[sfr_pkg::PATTERN_MAX-1] = i_text.text_byte;
        n_work = {1'b0, r_cnt} + sfr_pkg::LEN_W'(1);

        // ok[s] is set when the bytes from position s on are a prefix of the pattern.
        for (int s = 0; s <= sfr_pkg::PATTERN_MAX; s++) begin
            ok[s] = 1'b1;
            for (int i = 0; i < sfr_pkg::PATTERN_MAX; i++) begin
                if ((i + s < sfr_pkg::PATTERN_MAX) && (i + s < int'(n_work)) &&
                    (work[i+s] != i_cfg.pattern[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W])) begin
                    ok[s] = 1'b0;
                end
            end
        end
        shift = sfr_pkg::LEN_W'(sfr_pkg::PATTERN_MAX);
        for (int s = sfr_pkg::PATTERN_MAX; s >= 0; s--) begin
            if (ok[s]) begin
                shift = sfr_pkg::LEN_W'(s);
            end
        end

        // Classify: pass everything through, release leading bytes, or match.
        passthru = (i_cfg.plen == '0) || (n_work > i_cfg.plen);
        rel      = passthru ? n_work : shift;
        keep     = n_work - rel;
        match    = !passthru && (keep == i_cfg.plen);

        if (match || i_text.text_end) begin
            n_cnt = '0;
        end else begin
            n_cnt = keep[sfr_pkg::CNT_W-1:0];
        end

        // The bytes that stay pending move down to the front of the buffer.
        for (int i = 0; i < sfr_pkg::BUF_DEPTH; i++) begin
            n_buf[i] = work[i];
            for (int r = 1; r < sfr_pkg::PATTERN_MAX; r++) begin
                if ((rel == sfr_pkg::LEN_W'(r)) && (i + r < sfr_pkg::PATTERN_MAX)) begin
                    n_buf[i] = work[i+r];
                end
            end
        end

        // Build the run command for the back end.
        o_cmd.lit      = work;
        o_cmd.lit_cnt  = (i_text.text_end && !match) ? n_work : rel;
        o_cmd.text_end = i_text.text_end;
        beats          = o_cmd.lit_cnt + (match ? i_cfg.rlen : '0);
        o_cmd.marker   = i_text.text_end && (beats == '0);
        o_cmd.beats_m1 = (beats == '0) ? '0 : sfr_pkg::CNT_W'(beats - sfr_pkg::LEN_W'(1));
        o_push         = accept && ((beats != '0) || i_text.text_end);
    end

    // Pending count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    // Pending bytes; an entry is read only after it was written.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_buf;
        end
    end

endmodule

// ===== src/sfr_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on sfr_pkg and the assertion macro header.
`include "stream_find_and_replace_assert.svh"

module sfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output sfr_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    sfr_pkg::t_cmd             r_mem [sfr_pkg::Q_DEPTH];
    logic [sfr_pkg::Q_AW-1:0]  r_wr;
    logic [sfr_pkg::Q_AW-1:0]  r_rd;
    logic [sfr_pkg::Q_CW-1:0]  r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == sfr_pkg::Q_CW'(sfr_pkg::Q_DEPTH));
    assign o_head  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + sfr_pkg::Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + sfr_pkg::Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + sfr_pkg::Q_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - sfr_pkg::Q_CW'(1);
            end
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    `SFR_ASSERT_NOW(a_no_overflow, i_push && !i_pop, !o_full, "queue overflow")
    `SFR_ASSERT_NOW(a_no_underflow, i_pop, !o_empty, "queue underflow")
    `SFR_ASSERT_NOW(a_count_range, 1'b1, r_count <= sfr_pkg::Q_CW'(sfr_pkg::Q_DEPTH),
        "queue count out of range")

endmodule

// ===== src/sfr_back.sv =====
// Back end: expands run commands into beats, one beat per cycle while ready is high.
// Depends on sfr_pkg, sfr_out_if and the assertion macro header.
`include "stream_find_and_replace_assert.svh"

module sfr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfr_pkg::t_cmd i_head,
    input  logic          i_empty,
    input  sfr_pkg::t_cfg i_cfg,
    output logic          o_pop,
    sfr_out_if.source     o_text
);

    logic                       r_busy;
    sfr_pkg::t_cmd              r_cmd;
    logic [sfr_pkg::CNT_W-1:0]  r_pos;
    logic                       last;
    logic                       fire;
    logic [sfr_pkg::LEN_W-1:0]  ridx;

    assign last  = (r_pos == r_cmd.beats_m1);
    assign fire  = o_text.valid && o_text.ready;
    assign o_pop = (!r_busy || (fire && last)) && !i_empty;

    // Beat payload: literal bytes first, then replacement bytes, or the end marker.
    always_comb begin
        ridx = {1'b0, r_pos} - r_cmd.lit_cnt;
        o_text.valid      = r_busy;
        o_text.byte_valid = !r_cmd.marker;
        o_text.run_last   = last;
        o_text.output_end = last && r_cmd.text_end;
        if (r_cmd.marker) begin
            o_text.out_byte = '0;
        end else if ({1'b0, r_pos} < r_cmd.lit_cnt) begin
            o_text.out_byte = r_cmd.lit[r_pos];
        end else begin
            o_text.out_byte =
                i_cfg.repl[ridx[sfr_pkg::CNT_W-1:0]*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
        end
    end

    // Run sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (fire && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
            r_pos <= '0;
        end else if (fire && !last) begin
            r_pos <= r_pos + sfr_pkg::CNT_W'(1);
        end
    end

    `SFR_ASSERT_NOW(a_marker_ends, o_text.valid && !o_text.byte_valid,
        o_text.run_last && o_text.output_end, "end marker not flagged as final beat")
    `SFR_ASSERT_NOW(a_end_is_last, o_text.valid && o_text.output_end, o_text.run_last,
        "text end on a beat that does not close its run")
    `SFR_ASSERT_NEXT(a_stall_holds, o_text.valid && !o_text.ready,
        o_text.valid && $stable(r_pos), "beat position moved while stalled")

endmodule

// ===== src/stream_find_and_replace.sv =====
// Top level of the stream find-and-replace block.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_front, sfr_queue and sfr_back.

// Replaces every non-overlapping occurrence of the configured pattern (up to eight
// bytes) in a byte stream by the configured replacement (up to eight bytes). A text
// byte is taken every cycle while the two-entry command queue has room; a byte that
// only extends a possible match produces no beat. The output side sends one beat per
// cycle while the output is ready, so the sustained rate is one text byte per cycle
// as long as each byte yields at most one beat; a match adds the replacement bytes
// to the output, and the flush at text end up to eight bytes, with the input stalling
// once the queue fills. The first beat of a byte passes through the command queue
// and the run register of the back end before it is valid. A text end that leaves
// nothing to send yields one beat with byte_valid low. Write the configuration only
// while no text is in flight; there is no clearing pass after reset.
module stream_find_and_replace (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sfr_in_if.sink                         i_text,
    sfr_out_if.source                      o_text,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [sfr_pkg::CFG_DATA_W-1:0] r_pattern;
    logic [sfr_pkg::LEN_W-1:0]      r_plen;
    logic [sfr_pkg::CFG_DATA_W-1:0] r_repl;
    logic [sfr_pkg::LEN_W-1:0]      r_rlen;
    sfr_pkg::t_cfg                  cfg;
    sfr_pkg::t_cmd                  push_cmd;
    sfr_pkg::t_cmd                  head_cmd;
    logic                           push;
    logic                           pop;
    logic                           q_empty;
    logic                           q_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= '0;
            r_repl    <= '0;
            r_rlen    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfr_pkg::CFG_PATTERN_BYTES:      r_pattern <= i_cfg_data;
                sfr_pkg::CFG_PATTERN_LENGTH:     r_plen    <= i_cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::CFG_REPLACEMENT_BYTES:  r_repl    <= i_cfg_data;
                sfr_pkg::CFG_REPLACEMENT_LENGTH: r_rlen    <= i_cfg_data[sfr_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp oversized lengths to the hardware maximum.
    always_comb begin
        cfg.pattern = r_pattern;
        cfg.repl    = r_repl;
        cfg.plen    = (r_plen > sfr_pkg::LEN_W'(sfr_pkg::PATTERN_MAX)) ?
                      sfr_pkg::LEN_W'(sfr_pkg::PATTERN_MAX) : r_plen;
        cfg.rlen    = (r_rlen > sfr_pkg::LEN_W'(sfr_pkg::REPLACE_MAX)) ?
                      sfr_pkg::LEN_W'(sfr_pkg::REPLACE_MAX) : r_rlen;
    end

    sfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (i_text),
        .i_cfg   (cfg),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_cmd),
        .i_empty (q_empty),
        .i_cfg   (cfg),
        .o_pop   (pop),
        .o_text  (o_text)
    );

endmodule
